// ===== sv/bldc_hall_commutation_and_control_unit_assert.svh =====
// Assertion helpers for the motor control block.
// Both macros sample on clk_i and are switched off while rst_ni is low.
`ifndef BLDC_HALL_COMMUTATION_AND_CONTROL_UNIT_ASSERT_SVH
`define BLDC_HALL_COMMUTATION_AND_CONTROL_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BHCC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("bhcc: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define BHCC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("bhcc: next-cycle check failed");

`endif

// ===== sv/bhcc_pkg.sv =====
`default_nettype none

package bhcc_pkg;

  // Controller constants.
  localparam int unsigned MAX_POWER        = 1000;
  localparam int unsigned TICKS_PER_SECOND = 10;
  localparam int unsigned REPORT_EVERY     = 10;
  localparam int unsigned NUM_DRIVE        = 6;
  localparam int unsigned TICK_CNT_W       = $clog2(REPORT_EVERY + 1);

  // Fixed-point scaling: targets carry four fraction bits, the rotation
  // controller result is scaled down by 32 (Kp doubled, Kd in halves).
  localparam int unsigned Q_FRAC   = 4;
  localparam int unsigned YR_SHIFT = 5;

  // Unsigned 32-bit divide by six through a reciprocal multiply.
  localparam logic [31:0] DIV6_MAGIC = 32'hAAAA_AAAB;
  localparam int unsigned DIV6_SHIFT = 34;
  localparam int unsigned QUOT_W     = 29;

  // Reset values.
  localparam logic [9:0]         RESET_POWER        = 10'd300;
  localparam logic [2:0]         RESET_ROTOR_OFFSET = 3'd0;
  localparam logic signed [15:0] RESET_TARGET_SPEED = 16'sd720;
  localparam logic signed [31:0] RESET_TARGET_TURNS = 32'sd7344;
  localparam logic [7:0]         RESET_SPEED_GAIN   = 8'd22;
  localparam logic [7:0]         RESET_POSITION_GAIN = 8'd22;
  localparam logic [7:0]         RESET_DERIV_GAIN   = 8'd31;

  // Work queue between front and back.
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Gate patterns per drive state, and rotor state per sensor pattern.
  localparam logic [5:0] GATE_TABLE [8] = '{
    6'h12, 6'h18, 6'h09, 6'h21, 6'h24, 6'h06, 6'h00, 6'h00
  };
  localparam logic [2:0] ROTOR_TABLE [8] = '{
    3'd7, 3'd5, 3'd3, 3'd4, 3'd1, 3'd0, 3'd2, 3'd7
  };

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_ROTOR_OFFSET  = 3'd0,
    CFG_TARGET_SPEED  = 3'd1,
    CFG_TARGET_TURNS  = 3'd2,
    CFG_SPEED_GAIN    = 3'd3,
    CFG_POSITION_GAIN = 3'd4,
    CFG_DERIV_GAIN    = 3'd5
  } cfg_idx_e;

  typedef enum logic {
    KIND_HALL = 1'b0,
    KIND_TICK = 1'b1
  } item_kind_e;

  typedef struct packed {
    logic       kind;
    logic [2:0] hall_bits;
  } in_item_t;

  typedef struct packed {
    logic [5:0]         phase_drive;
    logic [9:0]         pulse_width;
    logic               report_valid;
    logic signed [31:0] speed_report;
    logic signed [31:0] position_report;
  } out_item_t;

  typedef struct packed {
    logic [2:0]         rotor_offset;
    logic signed [15:0] target_speed_q4;
    logic signed [31:0] target_turns_q4;
    logic [7:0]         speed_gain;
    logic [7:0]         position_gain;
    logic [7:0]         derivative_gain_half;
  } cfg_t;

  // Classified item as it waits in the queue.
  typedef struct packed {
    item_kind_e kind;
    logic [2:0] rotor;
  } work_t;

  typedef struct packed {
    logic              full;
    logic              empty;
    logic [QCNT_W-1:0] count;
  } q_status_t;

  // C-style remainder by six, folded to three bits. The sum lies in -3..15.
  function automatic logic [2:0] drive_index(logic signed [4:0] sum);
    logic signed [4:0] r;
    if (sum < 0) begin
      r = sum;
    end else if (sum >= $signed(5'(2 * NUM_DRIVE))) begin
      r = sum - $signed(5'(2 * NUM_DRIVE));
    end else if (sum >= $signed(5'(NUM_DRIVE))) begin
      r = sum - $signed(5'(NUM_DRIVE));
    end else begin
      r = sum;
    end
    return r[2:0];
  endfunction

endpackage

`default_nettype wire

// ===== sv/bhcc_front.sv =====
`default_nettype none

module bhcc_front import bhcc_pkg::*; (
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_data_i,
  input  q_status_t q_status_i,
  output logic      push_o,
  output work_t     push_data_o
);

  // Take an item whenever the queue has room.
  assign in_ready_o = !q_status_i.full;
  assign push_o     = in_valid_i && !q_status_i.full;

  // Classify the item and decode the sensor pattern to a rotor state.
  always_comb begin
    push_data_o.kind  = item_kind_e'(in_data_i.kind);
    push_data_o.rotor = ROTOR_TABLE[in_data_i.hall_bits];
  end

endmodule

`default_nettype wire

// ===== sv/bhcc_queue.sv =====
`default_nettype none

module bhcc_queue import bhcc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  work_t     push_data_i,
  input  logic      pop_i,
  output work_t     pop_data_o,
  output q_status_t status_o
);

  work_t             entry_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;

  // Pointer and fill count updates.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({push_i, pop_i})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign pop_data_o     = entry_q[rd_ptr_q];
  assign status_o.full  = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign status_o.empty = (count_q == '0);
  assign status_o.count = count_q;

endmodule

`default_nettype wire

// ===== sv/bhcc_back.sv =====
`default_nettype none

module bhcc_back import bhcc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  q_status_t q_status_i,
  input  work_t     pop_data_i,
  output logic      pop_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);

  // Tick sequencer: one state per pipeline step of the control update.
  typedef enum logic [5:0] {
    ST_READY = 6'b000001,
    ST_VEL   = 6'b000010,
    ST_ERR   = 6'b000100,
    ST_MUL   = 6'b001000,
    ST_SCALE = 6'b010000,
    ST_DONE  = 6'b100000
  } state_e;

  state_e state_q, state_d;

  // Architectural state.
  logic [31:0]           position_q, position_d;
  logic [2:0]            last_rotor_q, last_rotor_d;
  logic [5:0]            drive_mask_q, drive_mask_d;
  logic [9:0]            power_q, power_d;
  logic                  rev_q, rev_d;
  logic [31:0]           prev_pos_q, prev_pos_d;
  logic [TICK_CNT_W-1:0] tick_cnt_q, tick_cnt_d;
  logic signed [31:0]    prev_err_q, prev_err_d;

  // Tick pipeline registers.
  logic [31:0]        delta_q;
  logic               pos_neg_q;
  logic [QUOT_W-1:0]  quot_q;
  logic               report_q;
  logic [31:0]        vel_q;
  logic signed [31:0] err_q, err_d;
  logic signed [36:0] se_q, se_d;
  logic signed [32:0] derr_q, derr_d;
  logic signed [45:0] ys_prod_q, ys_prod_d;
  logic signed [40:0] p_prod_q, p_prod_d;
  logic signed [41:0] d_prod_q, d_prod_d;
  logic signed [41:0] ys_q, ys_d;
  logic signed [41:0] yr_q, yr_d;

  // Output register.
  logic      out_valid_q, out_valid_d;
  out_item_t out_data_q, out_data_d;

  // Handshake and dispatch.
  logic out_free, is_tick, hall_fire, tick_start, done_fire;

  // Hall edge datapath.
  logic signed [4:0] rotor_s, off_s, lead_s, drive_sum;
  logic [2:0]        drive_idx;
  logic signed [3:0] rot_diff, pos_step;

  // Tick datapath.
  logic [31:0]           pos_abs;
  logic [63:0]           div_prod;
  logic [TICK_CNT_W-1:0] tick_next;
  logic                  report_hit;
  logic signed [34:0]    quot_signed, err_full;
  logic [31:0]           vel_abs;
  logic signed [36:0]    ts_ext;
  logic signed [8:0]     sg_s, pg_s, dg_s;
  logic signed [45:0]    ys_bias;
  logic signed [41:0]    ys_base;
  logic signed [42:0]    yr_sum, yr_bias;
  logic signed [41:0]    torque, torque_mag;
  logic                  pick_ys;
  logic [9:0]            power_new;

  assign out_free   = !out_valid_q || out_ready_i;
  assign is_tick    = (pop_data_i.kind == KIND_TICK);
  assign pop_o      = (state_q == ST_READY) && !q_status_i.empty && (is_tick || out_free);
  assign hall_fire  = pop_o && !is_tick;
  assign tick_start = pop_o && is_tick;
  assign done_fire  = (state_q == ST_DONE) && out_free;

  // Hall edge: drive state from rotor, offset and lead; position step.
  always_comb begin
    rotor_s   = $signed({2'b00, pop_data_i.rotor});
    off_s     = $signed({2'b00, cfg_i.rotor_offset});
    lead_s    = rev_q ? -5'sd2 : 5'sd2;
    drive_sum = rotor_s - off_s + lead_s + $signed(5'(NUM_DRIVE));
    drive_idx = drive_index(drive_sum);
    rot_diff  = $signed({1'b0, pop_data_i.rotor}) - $signed({1'b0, last_rotor_q});
    if (rot_diff == 4'sd5) begin
      pos_step = -4'sd1;
    end else if (rot_diff == -4'sd5) begin
      pos_step = 4'sd1;
    end else begin
      pos_step = rot_diff;
    end
  end

  // First tick step: position magnitude divided by six, report count.
  always_comb begin
    pos_abs    = position_q[31] ? (~position_q + 32'd1) : position_q;
    div_prod   = 64'(pos_abs) * 64'(DIV6_MAGIC);
    tick_next  = tick_cnt_q + 1'b1;
    report_hit = (tick_next >= TICK_CNT_W'(REPORT_EVERY));
  end

  // Second tick step: turn error in Q4, saturated to 32 bits.
  always_comb begin
    quot_signed = pos_neg_q ? -$signed({6'b0, quot_q}) : $signed({6'b0, quot_q});
    err_full    = $signed({{3{cfg_i.target_turns_q4[31]}}, cfg_i.target_turns_q4})
                  - (quot_signed <<< Q_FRAC);
    if (err_full[34:31] != {4{err_full[34]}}) begin
      err_d = err_full[34] ? $signed(32'h8000_0000) : $signed(32'h7FFF_FFFF);
    end else begin
      err_d = err_full[31:0];
    end
  end

  // Third tick step: speed error and error difference.
  always_comb begin
    vel_abs = vel_q[31] ? (~vel_q + 32'd1) : vel_q;
    ts_ext  = 37'(cfg_i.target_speed_q4);
    se_d    = ts_ext * $signed(37'(NUM_DRIVE)) - $signed({1'b0, vel_abs, 4'b0000});
    derr_d  = $signed({err_q[31], err_q}) - $signed({prev_err_q[31], prev_err_q});
  end

  // Fourth tick step: gain products.
  always_comb begin
    sg_s      = $signed({1'b0, cfg_i.speed_gain});
    pg_s      = $signed({1'b0, cfg_i.position_gain});
    dg_s      = $signed({1'b0, cfg_i.derivative_gain_half});
    ys_prod_d = sg_s * se_q;
    p_prod_d  = pg_s * err_q;
    d_prod_d  = dg_s * derr_q;
  end

  // Fifth tick step: scale both controller outputs, truncating toward zero.
  always_comb begin
    ys_bias = ys_prod_q + (ys_prod_q[45] ? $signed(46'((1 << Q_FRAC) - 1)) : 46'sd0);
    if (cfg_i.target_speed_q4 == 16'sd0) begin
      ys_base = $signed(42'(MAX_POWER));
    end else begin
      ys_base = ys_bias[45:Q_FRAC];
    end
    ys_d    = err_q[31] ? -ys_base : ys_base;
    yr_sum  = $signed({p_prod_q[40], p_prod_q, 1'b0}) + $signed({d_prod_q[41], d_prod_q});
    yr_bias = yr_sum + (yr_sum[42] ? $signed(43'((1 << YR_SHIFT) - 1)) : 43'sd0);
    yr_d    = 42'($signed(yr_bias[42:YR_SHIFT]));
  end

  // Last tick step: torque choice, direction and clamp.
  always_comb begin
    pick_ys    = (!vel_q[31] && (ys_q < yr_q)) || (vel_q[31] && (ys_q > yr_q));
    torque     = pick_ys ? ys_q : yr_q;
    torque_mag = torque[41] ? -torque : torque;
    if (torque_mag > $signed(42'(MAX_POWER))) begin
      power_new = 10'(MAX_POWER);
    end else begin
      power_new = torque_mag[9:0];
    end
  end

  // State and output updates.
  always_comb begin
    state_d      = state_q;
    position_d   = position_q;
    last_rotor_d = last_rotor_q;
    drive_mask_d = drive_mask_q;
    power_d      = power_q;
    rev_d        = rev_q;
    prev_pos_d   = prev_pos_q;
    tick_cnt_d   = tick_cnt_q;
    prev_err_d   = prev_err_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_data_d   = out_data_q;

    unique case (state_q)
      ST_READY: begin
        if (hall_fire) begin
          drive_mask_d = GATE_TABLE[drive_idx];
          position_d   = position_q + {{28{pos_step[3]}}, pos_step};
          last_rotor_d = pop_data_i.rotor;
          out_valid_d  = 1'b1;
          out_data_d.phase_drive     = GATE_TABLE[drive_idx];
          out_data_d.pulse_width     = power_q;
          out_data_d.report_valid    = 1'b0;
          out_data_d.speed_report    = '0;
          out_data_d.position_report = '0;
        end else if (tick_start) begin
          prev_pos_d = position_q;
          tick_cnt_d = report_hit ? '0 : tick_next;
          state_d    = ST_VEL;
        end
      end
      ST_VEL:   state_d = ST_ERR;
      ST_ERR: begin
        prev_err_d = err_q;
        state_d    = ST_MUL;
      end
      ST_MUL:   state_d = ST_SCALE;
      ST_SCALE: state_d = ST_DONE;
      ST_DONE: begin
        if (done_fire) begin
          power_d     = power_new;
          rev_d       = torque[41];
          out_valid_d = 1'b1;
          out_data_d.phase_drive     = drive_mask_q;
          out_data_d.pulse_width     = power_new;
          out_data_d.report_valid    = report_q;
          out_data_d.speed_report    = report_q ? $signed(vel_q) : 32'sd0;
          out_data_d.position_report = report_q ? $signed(position_q) : 32'sd0;
          state_d = ST_READY;
        end
      end
      default:  state_d = ST_READY;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_READY;
      position_q   <= '0;
      last_rotor_q <= '0;
      drive_mask_q <= '0;
      power_q      <= RESET_POWER;
      rev_q        <= 1'b0;
      prev_pos_q   <= '0;
      tick_cnt_q   <= '0;
      prev_err_q   <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      position_q   <= position_d;
      last_rotor_q <= last_rotor_d;
      drive_mask_q <= drive_mask_d;
      power_q      <= power_d;
      rev_q        <= rev_d;
      prev_pos_q   <= prev_pos_d;
      tick_cnt_q   <= tick_cnt_d;
      prev_err_q   <= prev_err_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Pipeline payload registers, loaded in the step that produces them.
  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
    if (tick_start) begin
      delta_q   <= position_q - prev_pos_q;
      pos_neg_q <= position_q[31];
      quot_q    <= div_prod[DIV6_SHIFT + QUOT_W - 1:DIV6_SHIFT];
      report_q  <= report_hit;
    end
    if (state_q == ST_VEL) begin
      vel_q <= delta_q * 32'(TICKS_PER_SECOND);
      err_q <= err_d;
    end
    if (state_q == ST_ERR) begin
      se_q   <= se_d;
      derr_q <= derr_d;
    end
    if (state_q == ST_MUL) begin
      ys_prod_q <= ys_prod_d;
      p_prod_q  <= p_prod_d;
      d_prod_q  <= d_prod_d;
    end
    if (state_q == ST_SCALE) begin
      ys_q <= ys_d;
      yr_q <= yr_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

// ===== sv/bldc_hall_commutation_and_control_unit.sv =====
// Six-step Hall commutation with speed and rotation control for a BLDC motor.
// Input channel (in_valid_i/in_ready_o/in_data_i): each item is either a Hall
// sensor edge (kind 0, hall_bits) or a 100 ms control tick (kind 1).
// Output channel (out_valid_o/out_ready_i/out_data_o): exactly one result item
// per input item, in order: gate pattern, pulse width, and on every tenth tick
// a speed and position report.
// Configuration: cfg_we_i writes cfg_wdata_i into register cfg_idx_i at once;
// write only while the block is idle. Unknown indexes are ignored.
// A Hall edge result is registered in the output register; a tick result
// runs first through a six-step sequencer (divide by six, error, gain
// multiplies, scaling, clamp). Throughput: one Hall edge per cycle while the
// receiver is ready; a tick holds the execution side through its sequencer
// while the two-entry queue keeps accepting items.
// A stalled receiver holds the result in the output register; the back side
// keeps working until it has a new result, then waits; the queue fills and
// in_ready_o drops when it is full.
// Reset clears position and drive state, sets power to 300 and loads the
// default gains and targets.
`default_nettype none
`include "bldc_hall_commutation_and_control_unit_assert.svh"

module bldc_hall_commutation_and_control_unit import bhcc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_item_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_item_t   out_data_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i
);

  cfg_t      cfg_q;
  q_status_t q_status;
  logic      push, pop;
  work_t     push_data, pop_data;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rotor_offset         <= RESET_ROTOR_OFFSET;
      cfg_q.target_speed_q4      <= RESET_TARGET_SPEED;
      cfg_q.target_turns_q4      <= RESET_TARGET_TURNS;
      cfg_q.speed_gain           <= RESET_SPEED_GAIN;
      cfg_q.position_gain        <= RESET_POSITION_GAIN;
      cfg_q.derivative_gain_half <= RESET_DERIV_GAIN;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ROTOR_OFFSET:  cfg_q.rotor_offset         <= cfg_wdata_i[2:0];
        CFG_TARGET_SPEED:  cfg_q.target_speed_q4      <= $signed(cfg_wdata_i[15:0]);
        CFG_TARGET_TURNS:  cfg_q.target_turns_q4      <= $signed(cfg_wdata_i);
        CFG_SPEED_GAIN:    cfg_q.speed_gain           <= cfg_wdata_i[7:0];
        CFG_POSITION_GAIN: cfg_q.position_gain        <= cfg_wdata_i[7:0];
        CFG_DERIV_GAIN:    cfg_q.derivative_gain_half <= cfg_wdata_i[7:0];
        default:           cfg_q <= cfg_q;
      endcase
    end
  end

  // Front side: accept and classify.
  bhcc_front u_front (
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .q_status_i  (q_status),
    .push_o      (push),
    .push_data_o (push_data)
  );

  // Work queue between the two sides.
  bhcc_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .status_o    (q_status)
  );

  // Back side: commutation and control update.
  bhcc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_status_i  (q_status),
    .pop_data_i  (pop_data),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // The power never leaves the clamp range.
  `BHCC_ASSERT_IMP(a_power_clamped, out_valid_o, out_data_o.pulse_width <= 10'(MAX_POWER))
  // Without a report flag both report fields are zero.
  `BHCC_ASSERT_IMP(a_report_zero, out_valid_o && !out_data_o.report_valid, out_data_o.speed_report == 32'sd0 && out_data_o.position_report == 32'sd0)
  // A full queue is never pushed and an empty queue is never popped.
  `BHCC_ASSERT_IMP(a_queue_guard, 1'b1, !(push && q_status.full) && !(pop && q_status.empty))
  // A push without a pop raises the fill count by one over the previous cycle.
  `BHCC_ASSERT_NXT(a_queue_count, push && !pop, q_status.count == $past(q_status.count) + 1'b1)

endmodule

`default_nettype wire
